// ----- src/implicit_octree_node_indexer_core_assert.svh -----
// Assertion macros for the octree node indexer core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef IMPLICIT_OCTREE_NODE_INDEXER_CORE_ASSERT_SVH
`define IMPLICIT_OCTREE_NODE_INDEXER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define IONI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define IONI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ioni_pkg.sv -----
// Shared types, constants and the level offset table for the octree indexer.
// No dependencies.
package ioni_pkg;

  // Deepest level the hardware supports
  localparam int MAX_DEPTH = 7;
  // Entries of the level offset table: levels 0 .. MAX_DEPTH + 1
  localparam int TAB_DEPTH = MAX_DEPTH + 2;
  localparam int TAB_IDX_W = $clog2(TAB_DEPTH);

  localparam int NODE_W   = 22;
  localparam int LEVEL_W  = 3;
  localparam int INDEX_W  = 21;
  localparam int PARENT_W = 19;
  localparam int CHILD_W  = 22;
  localparam int SIB_W    = 3;

  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [PARENT_W-1:0]  parent_t;
  typedef logic [CHILD_W-1:0]   child_t;
  typedef logic [SIB_W-1:0]     sib_t;
  typedef logic [TAB_IDX_W-1:0] tab_idx_t;

  typedef node_t offset_tab_t [TAB_DEPTH];

  // One decoded result item
  typedef struct packed {
    logic    exists;
    level_t  tree_level;
    index_t  index_in_level;
    logic    has_parent;
    parent_t parent_number;
    logic    has_children;
    child_t  first_child_number;
    sib_t    sibling_position;
  } result_t;

  // First flat index of every level: (8^k - 1) / 7
  function automatic offset_tab_t offset_table();
    offset_tab_t tab;
    node_t       v;
    v = '0;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      tab[k] = v;
      v = node_t'({v, 3'b000}) + node_t'(1);
    end
    return tab;
  endfunction

  localparam offset_tab_t LEVEL_OFFSET = offset_table();

endpackage

// ----- src/ioni_in_if.sv -----
// Query channel interface: valid/ready with one node number.
// Depends on ioni_pkg.
interface ioni_in_if;
  logic           valid;
  logic           ready;
  ioni_pkg::node_t node_number;

  modport source (output valid, output node_number, input ready);
  modport sink   (input valid, input node_number, output ready);
endinterface

// ----- src/ioni_out_if.sv -----
// Result channel interface: valid/ready with the decoded node fields.
// Depends on ioni_pkg.
interface ioni_out_if;
  logic              valid;
  logic              ready;
  logic              exists;
  ioni_pkg::level_t  tree_level;
  ioni_pkg::index_t  index_in_level;
  logic              has_parent;
  ioni_pkg::parent_t parent_number;
  logic              has_children;
  ioni_pkg::child_t  first_child_number;
  ioni_pkg::sib_t    sibling_position;

  modport source (output valid, output exists, output tree_level, output index_in_level,
                  output has_parent, output parent_number, output has_children,
                  output first_child_number, output sibling_position, input ready);
  modport sink   (input valid, input exists, input tree_level, input index_in_level,
                  input has_parent, input parent_number, input has_children,
                  input first_child_number, input sibling_position, output ready);
endinterface

// ----- src/ioni_cfg_if.sv -----
// Configuration write channel: valid/ready with the deepest level value.
// Depends on ioni_pkg.
interface ioni_cfg_if;
  logic             valid;
  logic             ready;
  ioni_pkg::level_t deepest_level;

  modport source (output valid, output deepest_level, input ready);
  modport sink   (input valid, input deepest_level, output ready);
endinterface

// ----- src/ioni_decode.sv -----
// Combinational node decoder: level search, in-level index, parent and child.
// Depends on ioni_pkg for the level offset table and the result type.
module ioni_decode (
  input  ioni_pkg::node_t   node,
  input  ioni_pkg::level_t  depth,
  output ioni_pkg::result_t res
);

  ioni_pkg::level_t  depth_sat;
  ioni_pkg::level_t  lvl;
  ioni_pkg::node_t   limit;
  ioni_pkg::node_t   diff;
  ioni_pkg::node_t   par_base;
  ioni_pkg::node_t   child_base;
  ioni_pkg::node_t   par_sum;
  logic [ioni_pkg::NODE_W+2:0] child_sum;
  logic              exists;
  logic              hp;
  logic              hc;

  // Clamp the configured depth to what the table covers
  always_comb begin
    if (int'(depth) > ioni_pkg::MAX_DEPTH) begin
      depth_sat = ioni_pkg::level_t'(ioni_pkg::MAX_DEPTH);
    end else begin
      depth_sat = depth;
    end
  end

  // Find the level: highest level whose start is at or below the node
  always_comb begin
    lvl = '0;
    for (int k = 1; k <= ioni_pkg::MAX_DEPTH; k++) begin
      if (node >= ioni_pkg::LEVEL_OFFSET[k]) begin
        lvl = ioni_pkg::level_t'(k);
      end
    end
  end

  // Node exists when it lies below the start of the level past the deepest
  assign limit  = ioni_pkg::LEVEL_OFFSET[ioni_pkg::tab_idx_t'(depth_sat) +
                                         ioni_pkg::tab_idx_t'(1)];
  assign exists = node < limit;
  assign hp     = exists && (lvl != '0);
  assign hc     = exists && (lvl < depth_sat);

  assign diff       = node - ioni_pkg::LEVEL_OFFSET[ioni_pkg::tab_idx_t'(lvl)];
  assign par_base   = ioni_pkg::LEVEL_OFFSET[ioni_pkg::tab_idx_t'(lvl - ioni_pkg::level_t'(1))];
  assign child_base = ioni_pkg::LEVEL_OFFSET[ioni_pkg::tab_idx_t'(lvl) +
                                             ioni_pkg::tab_idx_t'(1)];
  assign par_sum    = (diff >> 3) + par_base;
  assign child_sum  = {diff, 3'b000} + (ioni_pkg::NODE_W+3)'(child_base);

  // Assemble the result; a missing node reports all zeros
  always_comb begin
    res = '0;
    if (exists) begin
      res.exists           = 1'b1;
      res.tree_level       = lvl;
      res.index_in_level   = diff[ioni_pkg::INDEX_W-1:0];
      res.sibling_position = diff[ioni_pkg::SIB_W-1:0];
      res.has_parent       = hp;
      res.has_children     = hc;
      if (hp) begin
        res.parent_number = par_sum[ioni_pkg::PARENT_W-1:0];
      end
      if (hc) begin
        res.first_child_number = child_sum[ioni_pkg::CHILD_W-1:0];
      end
    end
  end

endmodule

// ----- src/implicit_octree_node_indexer_core.sv -----
// Octree node indexer: an input register feeds the decoder, whose output lands
// in a result register. Throughput one query per cycle when the result channel
// does not stall; under backpressure both stages hold their items.
// Synchronous active-low reset empties both stages and sets the deepest level
// to 7. Configuration writes are always taken.
module implicit_octree_node_indexer_core (
  input  logic        clk,
  input  logic        rst_n,
  ioni_in_if.sink     in_ch,
  ioni_out_if.source  out_ch,
  ioni_cfg_if.sink    cfg_ch
);

  `include "implicit_octree_node_indexer_core_assert.svh"

  ioni_pkg::level_t  depth_r;
  logic              s1_valid_r;
  ioni_pkg::node_t   s1_node_r;
  logic              out_valid_r;
  ioni_pkg::result_t out_res_r;
  ioni_pkg::result_t dec_res;
  logic              out_free;
  logic              s1_free;

  // Stage enables: a stage takes new data when empty or when draining
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_ch.ready  = s1_free;
  assign cfg_ch.ready = 1'b1;

  // Hold the deepest level register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= ioni_pkg::level_t'(7);
    end else if (cfg_ch.valid) begin
      depth_r <= cfg_ch.deepest_level;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_node_r <= in_ch.node_number;
    end
  end

  ioni_decode u_decode (
    .node  (s1_node_r),
    .depth (depth_r),
    .res   (dec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_res_r <= dec_res;
    end
  end

  // Drive the result channel
  assign out_ch.valid              = out_valid_r;
  assign out_ch.exists             = out_res_r.exists;
  assign out_ch.tree_level         = out_res_r.tree_level;
  assign out_ch.index_in_level     = out_res_r.index_in_level;
  assign out_ch.has_parent         = out_res_r.has_parent;
  assign out_ch.parent_number      = out_res_r.parent_number;
  assign out_ch.has_children       = out_res_r.has_children;
  assign out_ch.first_child_number = out_res_r.first_child_number;
  assign out_ch.sibling_position   = out_res_r.sibling_position;

  // A missing node must report zero level, parent and child
  `IONI_ASSERT_NOW(a_missing_zero, out_valid_r && !out_res_r.exists, (out_res_r.tree_level == '0) && !out_res_r.has_parent && (out_res_r.parent_number == '0) && (out_res_r.first_child_number == '0), "missing node with nonzero fields")

  // Root has no parent, deepest supported level has no children
  `IONI_ASSERT_NOW(a_level_links, out_valid_r, (out_res_r.has_parent == (out_res_r.exists && (out_res_r.tree_level != '0))) && !(out_res_r.has_children && (int'(out_res_r.tree_level) == ioni_pkg::MAX_DEPTH)), "parent or child flag inconsistent with level")

  // A full input stage blocked by a stalled result keeps its item
  `IONI_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ch.ready, s1_valid_r && $stable(s1_node_r), "input stage lost a stalled item")

endmodule

// ----- tb/implicit_octree_node_indexer_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the octree node indexer core: random and boundary
// queries over several deepest-level settings, checked against a local decoder.
// Depends on ioni_pkg, the three channel interfaces and the core itself.
module implicit_octree_node_indexer_core_tb;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int PHASE_QUERIES = 145;
  localparam int TAIL_CYCLES   = 4;
  localparam int STALL_LIMIT   = 2000;

  logic clk;
  logic rst_n;

  ioni_in_if  in_ch ();
  ioni_out_if out_ch ();
  ioni_cfg_if cfg_ch ();

  ioni_pkg::node_t   pending_queries[$];
  ioni_pkg::result_t predicted_decodes[$];

  ioni_pkg::level_t depth_setting = ioni_pkg::level_t'(7);
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     mismatch_count = 0;
  int     query_count = 0;
  int     result_count = 0;
  int     depth_write_count = 0;
  int     quiet_cycles = 0;

  implicit_octree_node_indexer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  // First flat index of level k: (8^k - 1) / 7
  function automatic longint unsigned level_start(int k);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < k; i++) s = s * 8 + 1;
    return s;
  endfunction

  // Decode one node number against the given deepest level
  function automatic ioni_pkg::result_t decode_node(ioni_pkg::node_t node,
                                                    ioni_pkg::level_t depth_cfg);
    ioni_pkg::result_t res;
    int unsigned       depth;
    int unsigned       lvl;
    longint unsigned   first;
    longint unsigned   above;
    longint unsigned   below;
    longint unsigned   idx;
    res   = '0;
    depth = (int'(depth_cfg) > ioni_pkg::MAX_DEPTH) ? ioni_pkg::MAX_DEPTH : depth_cfg;
    first = 0;
    above = 0;
    lvl   = 0;
    // walk down until the node falls inside the current level
    while (longint'(node) >= first * 8 + 1) begin
      if (lvl >= depth) return res;
      above = first;
      first = first * 8 + 1;
      lvl++;
    end
    below = first * 8 + 1;
    idx   = node - first;
    res.exists           = 1'b1;
    res.tree_level       = ioni_pkg::level_t'(lvl);
    res.index_in_level   = ioni_pkg::index_t'(idx);
    res.has_parent       = (lvl > 0);
    res.parent_number    = (lvl > 0) ? ioni_pkg::parent_t'((idx >> 3) + above) : '0;
    res.has_children     = (lvl < depth);
    res.first_child_number = (lvl < depth) ? ioni_pkg::child_t'(idx * 8 + below) : '0;
    res.sibling_position = ioni_pkg::sib_t'(idx);
    return res;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Append one node number to the pending queue
  task automatic queue_node(ioni_pkg::node_t node);
    pending_queries = {pending_queries, node};
  endtask

  // Hold until every query has been sent and decoded, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_queries.size() != 0 || in_ch.valid || predicted_decodes.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write the deepest level through the configuration channel
  task automatic write_depth(ioni_pkg::level_t depth);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.deepest_level <= depth;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Query driver: advance to the next node after each transfer, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.node_number <= pending_queries.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: track the depth register, predict on query transfer, check on result transfer
  always @(posedge clk) begin : monitor
    ioni_pkg::result_t got;
    ioni_pkg::result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        depth_setting = cfg_ch.deepest_level;
        depth_write_count++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_decodes = {predicted_decodes,
                             decode_node(in_ch.node_number, depth_setting)};
        query_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        got.exists             = out_ch.exists;
        got.tree_level         = out_ch.tree_level;
        got.index_in_level     = out_ch.index_in_level;
        got.has_parent         = out_ch.has_parent;
        got.parent_number      = out_ch.parent_number;
        got.has_children       = out_ch.has_children;
        got.first_child_number = out_ch.first_child_number;
        got.sibling_position   = out_ch.sibling_position;
        if (predicted_decodes.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, actual 0x%0h", $time, got);
          mismatch_count++;
        end else begin
          want = predicted_decodes.pop_front();
          check_field("exists", want.exists, got.exists);
          check_field("tree_level", want.tree_level, got.tree_level);
          check_field("index_in_level", want.index_in_level, got.index_in_level);
          check_field("has_parent", want.has_parent, got.has_parent);
          check_field("parent_number", want.parent_number, got.parent_number);
          check_field("has_children", want.has_children, got.has_children);
          check_field("first_child_number", want.first_child_number,
                      got.first_child_number);
          check_field("sibling_position", want.sibling_position, got.sibling_position);
        end
      end
    end
  end

  // Watchdog: drop the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: boundary queries at the reset depth, then random phases per depth
  initial begin
    int              depth_plan[12];
    int              depth;
    int              pick;
    int              lvl;
    longint unsigned total;
    longint unsigned base;
    longint unsigned span;
    longint unsigned node;
    depth_plan = '{0, 7, 3, 1, 6, 2, 5, 4, 7, 0, 1, 6};
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.node_number    = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.deepest_level = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Level edges at the reset depth: last node of each level and first of the next
    for (int k = 0; k <= ioni_pkg::MAX_DEPTH + 1; k++) begin
      if (k > 0) queue_node(ioni_pkg::node_t'(level_start(k) - 1));
      queue_node(ioni_pkg::node_t'(level_start(k)));
    end
    queue_node(ioni_pkg::node_t'(8));
    queue_node(ioni_pkg::node_t'(16));
    queue_node(ioni_pkg::node_t'({ioni_pkg::NODE_W{1'b1}}));
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      depth = depth_plan[ph];
      write_depth(ioni_pkg::level_t'(depth));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      total = level_start(depth + 1);
      // Tree edges at this depth
      queue_node(ioni_pkg::node_t'(0));
      queue_node(ioni_pkg::node_t'(total - 1));
      queue_node(ioni_pkg::node_t'(total));
      queue_node(ioni_pkg::node_t'({ioni_pkg::NODE_W{1'b1}}));
      for (int i = 4; i < PHASE_QUERIES; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // uniform level, then uniform index within it
          lvl  = $urandom_range(0, depth);
          base = level_start(lvl);
          span = level_start(lvl + 1) - base;
          node = base + $urandom_range(0, int'(span - 1));
        end else if (pick < 60) begin
          // near a level boundary
          lvl  = $urandom_range(0, depth + 1);
          base = level_start(lvl);
          node = (base == 0) ? $urandom_range(0, 1) : base - 1 + $urandom_range(0, 2);
        end else if (pick < 85) begin
          node = $urandom_range(0, int'(total - 1));
        end else begin
          node = $urandom() & {ioni_pkg::NODE_W{1'b1}};
        end
        queue_node(ioni_pkg::node_t'(node));
      end
      wait_drained();
    end

    $display("Sent %0d node queries across %0d depth writes with mixed idling and stalls;",
             query_count, depth_write_count);
    $display("checked %0d decoded results, %0d field errors.", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ioni_pkg.sv
src/ioni_in_if.sv
src/ioni_out_if.sv
src/ioni_cfg_if.sv
src/ioni_decode.sv
src/implicit_octree_node_indexer_core.sv
tb/implicit_octree_node_indexer_core_tb.sv
